// ----- rtl/core/pca_pkg.sv -----
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants, types and the colour reduction for the palette allocator.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int PALETTE_ENTRIES  = 256;
  localparam int RESERVED_ENTRIES = 16;
  localparam int COUNT_BITS       = 24;

  localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W = 15;

  // low two bits of each five-bit channel
  localparam logic [COLOR_W-1:0] COLOR_CLEAR_MASK = 15'h0C63;

  // broadcast to every cell
  typedef struct packed {
    logic               dec_en;
    logic               inc_en;
    logic               wr_en;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // search probe handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } probe_t;

  function automatic logic [COLOR_W-1:0] reduce_color(input logic [23:0] rgb);
    logic [COLOR_W-1:0] c;
    c = {rgb[23:19], rgb[15:11], rgb[7:3]};
    return c & ~COLOR_CLEAR_MASK;
  endfunction

endpackage

// ----- rtl/core/pca_cell.sv -----
// ----------------------------------------------------------------------------
// pca_cell
// One palette entry: colour word, use count and one stage of the search probe.
// ----------------------------------------------------------------------------
module pca_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pca_pkg::IDX_W-1:0]   cell_idx,
  input  pca_pkg::cmd_t               cmd,
  input  pca_pkg::probe_t             probe_in,
  output pca_pkg::probe_t             probe_out
);

  logic [pca_pkg::COLOR_W-1:0]    color;
  logic [pca_pkg::COUNT_BITS-1:0] count;
  logic [pca_pkg::COUNT_BITS-1:0] count_next;

  logic                      probe_valid;
  logic                      probe_match_found;
  logic [pca_pkg::IDX_W-1:0] probe_match_idx;
  logic                      probe_free_found;
  logic [pca_pkg::IDX_W-1:0] probe_free_idx;

  logic sel;
  logic hit;
  logic free_here;

  assign sel       = (cmd.idx == cell_idx);
  assign hit       = (color == cmd.color);
  assign free_here = (32'(cell_idx) >= pca_pkg::RESERVED_ENTRIES) && (count == '0);

  always_comb begin
    count_next = count;
    if (cmd.dec_en && sel && (count != '0)) begin
      count_next = count - 1'b1;
    end else if (cmd.inc_en && sel && (count != '1)) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color       <= '0;
      count       <= '0;
      probe_valid <= 1'b0;
    end else begin
      count       <= count_next;
      probe_valid <= probe_in.valid;
      if (cmd.wr_en && sel) begin
        color <= cmd.color;
      end
    end
  end

  // first hit along the row wins
  always_ff @(posedge clk) begin
    probe_match_found <= probe_in.match_found | hit;
    probe_match_idx   <= probe_in.match_found ? probe_in.match_idx : cell_idx;
    probe_free_found  <= probe_in.free_found | free_here;
    probe_free_idx    <= probe_in.free_found ? probe_in.free_idx : cell_idx;
  end

  assign probe_out.valid       = probe_valid;
  assign probe_out.match_found = probe_match_found;
  assign probe_out.match_idx   = probe_match_idx;
  assign probe_out.free_found  = probe_free_found;
  assign probe_out.free_idx    = probe_free_idx;

endmodule

// ----- rtl/core/pca_chain.sv -----
// ----------------------------------------------------------------------------
// pca_chain
// Row of palette cells; the probe enters at entry 0 and leaves after the last.
// ----------------------------------------------------------------------------
module pca_chain (
  input  logic            clk,
  input  logic            rst,
  input  pca_pkg::cmd_t   cmd,
  input  logic            launch,
  output pca_pkg::probe_t result
);

  pca_pkg::probe_t probe [pca_pkg::PALETTE_ENTRIES+1];

  assign probe[0].valid       = launch;
  assign probe[0].match_found = 1'b0;
  assign probe[0].match_idx   = '0;
  assign probe[0].free_found  = 1'b0;
  assign probe[0].free_idx    = '0;

  for (genvar i = 0; i < pca_pkg::PALETTE_ENTRIES; i++) begin : g_cell
    pca_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (pca_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
  end

  assign result = probe[pca_pkg::PALETTE_ENTRIES];

endmodule

// ----- rtl/core/palette_color_allocator.sv -----
// ----------------------------------------------------------------------------
// palette_color_allocator
// Reference-counted 8-bit palette allocator for indexed pixel writes.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  pixel write item (x, y, old index, rgb)
// m_*      out  m_tvalid/m_tready  frame buffer address, index, DAC write
//
// Steps: the item is registered on acceptance, DEC releases the old index,
// LAUNCH starts the probe, SCAN waits while it walks the registered cell
// row, and FINISH commits the result. The next item is taken only in IDLE
// after commit, so one item is in flight at a time.
// Reset: synchronous; every cell's colour and count clear in the same cycle.
// Stalls: the result sits in an output register; a new item is accepted
// while it waits, and only the commit step holds until the register is free.
// ----------------------------------------------------------------------------
module palette_color_allocator (
  input  logic        clk,
  input  logic        rst,
  // s_tdata, low bit up: pixel_x[15:0], pixel_y[31:16], old_index[39:32],
  //                      rgb_color[63:40]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  // m_tdata, low bit up: write_x[15:0], write_y[31:16], palette_index[39:32],
  //                      dac_write[40], dac_red[46:41], dac_green[52:47],
  //                      dac_blue[58:53], palette_full[59], zero[63:60]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    DEC    = 5'b00010,
    LAUNCH = 5'b00100,
    SCAN   = 5'b01000,
    FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // item registers
  logic [15:0]                 pix_x;
  logic [15:0]                 pix_y;
  logic [7:0]                  old_idx;
  logic [pca_pkg::COLOR_W-1:0] color_q;

  // search outcome captured from the end of the row
  logic                      res_match_found;
  logic [pca_pkg::IDX_W-1:0] res_match_idx;
  logic                      res_free_found;
  logic [pca_pkg::IDX_W-1:0] res_free_idx;

  // output register
  logic        out_valid;
  logic [63:0] out_data;

  pca_pkg::cmd_t   cmd;
  pca_pkg::probe_t chain_out;

  logic                      s_fire;
  logic                      out_free;
  logic                      commit;
  logic [pca_pkg::IDX_W-1:0] chosen_idx;
  logic                      dac;
  logic                      full;
  logic [5:0]                dac_r;
  logic [5:0]                dac_g;
  logic [5:0]                dac_b;

  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign commit   = (state == FINISH) && out_free;

  // match beats allocation; with neither, entry 0 takes the pixel
  always_comb begin
    dac        = 1'b0;
    full       = 1'b0;
    chosen_idx = '0;
    if (res_match_found) begin
      chosen_idx = res_match_idx;
    end else if (res_free_found) begin
      chosen_idx = res_free_idx;
      dac        = 1'b1;
    end else begin
      full = 1'b1;
    end
  end

  assign dac_r = dac ? {color_q[14:10], 1'b0} : 6'd0;
  assign dac_g = dac ? {color_q[9:5],   1'b0} : 6'd0;
  assign dac_b = dac ? {color_q[4:0],   1'b0} : 6'd0;

  // cell commands: release in DEC, claim (and maybe store) at commit
  always_comb begin
    cmd.dec_en = (state == DEC) && (32'(old_idx) < pca_pkg::PALETTE_ENTRIES);
    cmd.inc_en = commit;
    cmd.wr_en  = commit && dac;
    cmd.idx    = (state == DEC) ? old_idx[pca_pkg::IDX_W-1:0] : chosen_idx;
    cmd.color  = color_q;
  end

  pca_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .launch (state == LAUNCH),
    .result (chain_out)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:    if (s_fire) state_next = DEC;
      DEC:     state_next = LAUNCH;
      LAUNCH:  state_next = SCAN;
      SCAN:    if (chain_out.valid) state_next = FINISH;
      FINISH:  if (out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      pix_x   <= s_tdata[15:0];
      pix_y   <= s_tdata[31:16];
      old_idx <= s_tdata[39:32];
      color_q <= pca_pkg::reduce_color(s_tdata[63:40]);
    end
    if ((state == SCAN) && chain_out.valid) begin
      res_match_found <= chain_out.match_found;
      res_match_idx   <= chain_out.match_idx;
      res_free_found  <= chain_out.free_found;
      res_free_idx    <= chain_out.free_idx;
    end
    if (commit) begin
      out_data <= {4'd0, full, dac_b, dac_g, dac_r, dac, 8'(chosen_idx), pix_y, pix_x};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // assertions
  a_probe_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> (state == SCAN))
    else $error("probe left the row outside the scan");

  a_dec_then_launch: assert property (@(posedge clk) disable iff (rst)
    (state == DEC) |=> (state == LAUNCH))
    else $error("release step not followed by launch");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[40] && out_data[59]))
    else $error("dac write and palette full together");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[59]) |-> (out_data[39:32] == 8'd0))
    else $error("palette full with non-zero index");

  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("commit did not load the output register");

endmodule
